[rtl/core/srm_pkg.sv]
// Shared types and constants of the smooth random modulator core.
// Used by srm_ctrl, srm_datapath and smooth_random_modulator_core; depends on nothing.
`default_nettype none

package srm_pkg;

    // Fixed field and register widths.
    localparam int LEN_W     = 24;
    localparam int SEED_W    = 32;
    localparam int OUT_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE     = 2'd1;

    localparam logic [LEN_W-1:0]  SEG_LEN_RESET = 24'd24000;
    localparam logic [SEED_W-1:0] SEED_RESET    = 32'h1234_5678;

    // xorshift32 shift amounts.
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    // Draw mapping: round(w * 2^(F+1) / (2^32 - 1)) through bias and divisor.
    localparam logic [SEED_W-1:0] MAP_BIAS = 32'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] MAP_DIV  = 32'hFFFF_FFFF;

    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    localparam int PRIME_DRAWS = 4;
    localparam int MUL_STEPS   = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } t_state;

    // Horner coefficient added after each product.
    typedef enum logic [1:0] {
        COEF_C,
        COEF_B,
        COEF_A
    } t_coef;

    typedef struct packed {
        logic  in_ready;
        logic  accept;
        logic  load_seed;
        logic  draw_shift;
        logic  div_step;
        logic  mul;
        logic  acc_add;
        t_coef coef_sel;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic seed_write;
        logic in_valid;
        logic out_free;
    } t_sts;

    function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] w);
        logic [SEED_W-1:0] x;
        x = w ^ (w << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        return x;
    endfunction

endpackage

`default_nettype wire

[rtl/core/srm_ctrl.sv]
// Sequencer of the smooth random modulator: priming, division, Horner steps, hand-off.
// Depends on srm_pkg; drives srm_datapath through the command struct.
`default_nettype none

module srm_ctrl #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  srm_pkg::t_sts i_sts,
    output srm_pkg::t_cmd o_cmd
);
    import srm_pkg::*;

    localparam int STEP_W = $clog2(FRACTION_BITS);
    localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(FRACTION_BITS - 1);
    localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] PRIME_LAST = STEP_W'(PRIME_DRAWS - 1);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_LOAD: begin
                n_state = ST_PRIME;
                n_step  = '0;
            end
            ST_PRIME: begin
                if (r_step == PRIME_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                end
            end
            ST_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = ST_MUL;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_MUL: begin
                if (r_step == MUL_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_LOAD;
        endcase
        // A new seed restarts priming from any state.
        if (i_sts.seed_write) begin
            n_state = ST_LOAD;
        end
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_LOAD:  o_cmd.load_seed  = 1'b1;
            ST_PRIME: o_cmd.draw_shift = 1'b1;
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_sts.in_valid;
            end
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_MUL: begin
                // Even steps multiply, odd steps add the next coefficient.
                o_cmd.mul      = ~r_step[0];
                o_cmd.acc_add  = r_step[0];
                o_cmd.coef_sel = t_coef'(r_step[2:1]);
            end
            ST_FIN:   o_cmd.finish = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/srm_datapath.sv]
// Datapath of the smooth random modulator: generator, history, segment counter,
// restoring divider for t and one shared multiplier for the Horner steps. Depends on srm_pkg.
`default_nettype none

module srm_datapath #(
    parameter int FRACTION_BITS = 16,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic                                 i_clk,
    input  srm_pkg::t_cmd                        i_cmd,
    input  logic                                 i_restart,
    input  logic [srm_pkg::LEN_W-1:0]            i_seg_len,
    input  logic [srm_pkg::SEED_W-1:0]           i_seed,
    output logic signed [srm_pkg::OUT_W-1:0]     o_result
);
    import srm_pkg::*;

    localparam int F     = FRACTION_BITS;
    localparam int HW    = F + 2;
    localparam int AW    = F + 7;
    localparam int PW    = AW + F + 1;
    localparam int REM_W = LEN_W + 1;
    localparam int NW    = SEED_W + F + 2;
    localparam int CMP_W = ((COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W) + 1;
    localparam int RW    = (AW > OUT_W) ? AW : OUT_W;

    logic [SEED_W-1:0]       r_rng;
    logic signed [HW-1:0]    r_hist [4];
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [REM_W-1:0]        r_rem;
    logic [F-1:0]            r_quot;
    logic                    r_sat;
    logic signed [AW-1:0]    r_acc;
    logic signed [PW-1:0]    r_prod;

    logic [LEN_W-1:0]        len_eff;
    logic [COUNT_WIDTH-1:0]  cnt_eff;
    logic [SEED_W-1:0]       x_next;
    logic [NW-1:0]           map_num;
    logic [F+1:0]            map_hi;
    logic [SEED_W:0]         map_sum;
    logic [F+1:0]            map_q;
    logic signed [HW-1:0]    draw_val;
    logic signed [AW-1:0]    pe [4];
    logic signed [AW-1:0]    coef_a, coef_b, coef_c, coef_d, coef_sel_val;
    logic signed [AW-1:0]    prod_floor;
    logic [F-1:0]            t_val;
    logic [REM_W-1:0]        rem2;
    logic                    rem_ge;
    logic                    seg_end;
    logic                    do_draw;
    logic signed [AW-1:0]    s_plus1;
    logic signed [AW-1:0]    half;
    logic signed [RW-1:0]    half_ext;

    // A zero segment length behaves as one.
    assign len_eff = (i_seg_len == '0) ? LEN_W'(1) : i_seg_len;
    assign cnt_eff = i_restart ? '0 : r_count;

    // q = floor(N / (2^32 - 1)) = hi + carry, since N = hi * (2^32 - 1) + hi + lo.
    assign x_next   = xorshift32(r_rng);
    assign map_num  = NW'({x_next, {(F + 1){1'b0}}}) + NW'(MAP_BIAS);
    assign map_hi   = map_num[NW-1:SEED_W];
    assign map_sum  = {1'b0, map_num[SEED_W-1:0]} + (SEED_W + 1)'(map_hi);
    assign map_q    = map_hi + (F + 2)'(map_sum >= {1'b0, MAP_DIV});
    assign draw_val = $signed(map_q - {2'b01, {F{1'b0}}});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pe[i] = {{(AW - HW){r_hist[i][HW-1]}}, r_hist[i]};
        end
    end

    assign coef_a = pe[1] <<< 1;
    assign coef_b = pe[2] - pe[0];
    assign coef_c = (pe[0] <<< 1) - ((pe[1] <<< 2) + pe[1]) + (pe[2] <<< 2) - pe[3];
    assign coef_d = pe[3] - pe[0] + ((pe[1] - pe[2]) <<< 1) + (pe[1] - pe[2]);

    always_comb begin
        case (i_cmd.coef_sel)
            COEF_C:  coef_sel_val = coef_c;
            COEF_B:  coef_sel_val = coef_b;
            default: coef_sel_val = coef_a;
        endcase
    end

    assign t_val      = r_sat ? '1 : r_quot;
    assign prod_floor = $signed(r_prod[F +: AW]);

    assign rem2   = {r_rem[REM_W-2:0], 1'b0};
    assign rem_ge = rem2 >= {1'b0, len_eff};

    assign seg_end = (CMP_W'(r_count) + CMP_W'(1)) >= CMP_W'(len_eff);
    assign do_draw = i_cmd.draw_shift | (i_cmd.finish & seg_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_rng <= i_seed;
        end else if (do_draw) begin
            r_rng <= x_next;
        end

        if (do_draw) begin
            r_hist[0] <= r_hist[1];
            r_hist[1] <= r_hist[2];
            r_hist[2] <= r_hist[3];
            r_hist[3] <= draw_val;
        end

        if (i_cmd.load_seed) begin
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_count <= cnt_eff;
        end else if (i_cmd.finish) begin
            r_count <= seg_end ? '0 : r_count + COUNT_WIDTH'(1);
        end

        if (i_cmd.accept) begin
            r_sat  <= CMP_W'(cnt_eff) >= CMP_W'(len_eff);
            r_rem  <= REM_W'(cnt_eff);
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem2 - {1'b0, len_eff} : rem2;
            r_quot <= {r_quot[F-2:0], rem_ge};
        end

        if (i_cmd.accept) begin
            r_acc <= coef_d;
        end else if (i_cmd.acc_add) begin
            r_acc <= coef_sel_val + prod_floor;
        end

        if (i_cmd.mul) begin
            r_prod <= r_acc * $signed({1'b0, t_val});
        end
    end

    // Final halving with rounding to nearest, ties toward plus infinity, then saturation.
    assign s_plus1  = r_acc + AW'(1);
    assign half     = s_plus1 >>> 1;
    assign half_ext = RW'(half);

    always_comb begin
        if (half_ext > RW'(OUT_MAX)) begin
            o_result = OUT_W'(OUT_MAX);
        end else if (half_ext < RW'(OUT_MIN)) begin
            o_result = OUT_W'(OUT_MIN);
        end else begin
            o_result = half_ext[OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/core/smooth_random_modulator_core.sv]
// Smooth random modulator: xorshift32 noise, four-point history, Catmull-Rom interpolation.
// Top level; depends on srm_pkg, srm_ctrl and srm_datapath.
//
// Usage: each request on the slave stream (tdata bit 0 = restart) produces one
// signed Q2.16 value on the master stream. Restart clears the segment counter
// before the value is computed; the history is kept.
// Configuration: index 0 writes segment_length, index 1 writes seed_value; other
// indexes are ignored. The channel is always ready. A seed write reloads the
// generator, makes four draws into the history and clears the counter; no request
// is taken while this runs.
// Reset loads segment_length = 24000 and seed 0x12345678 and runs the same
// priming before s_axis_tready rises.
// Sequence: an accepted request passes through the bit-per-cycle divider that forms t
// and the three multiply/add passes of the Horner evaluation on one shared multiplier,
// and the result then lands in the output register. One request is in flight at a time:
// the next request is accepted only after the current result has been handed off.
// Stall: the result register holds while m_axis_tready is low; the next request
// is still accepted and computed, and waits before hand-off until the register frees.
`default_nettype none

module smooth_random_modulator_core #(
    parameter int FRACTION_BITS = 16,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [17:0] mod_value, [23:18] zero
);
    import srm_pkg::*;

    logic [LEN_W-1:0]        r_seg_len;
    logic [SEED_W-1:0]       r_seed;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic                    cfg_fire;
    logic signed [OUT_W-1:0] dp_result;
    t_cmd                    w_cmd;
    t_sts                    w_sts;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= SEG_LEN_RESET;
            r_seed    <= SEED_RESET;
        end else if (cfg_fire) begin
            if (i_cfg_index == REG_SEGMENT_LENGTH) begin
                r_seg_len <= i_cfg_data[LEN_W-1:0];
            end else if (i_cfg_index == REG_SEED_VALUE) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    assign w_sts.seed_write = cfg_fire & (i_cfg_index == REG_SEED_VALUE);
    assign w_sts.in_valid   = s_axis_tvalid;
    assign w_sts.out_free   = ~r_out_valid | m_axis_tready;

    srm_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    srm_datapath #(
        .FRACTION_BITS(FRACTION_BITS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_restart(s_axis_tdata[0]),
        .i_seg_len(r_seg_len),
        .i_seed   (r_seed),
        .o_result (dp_result)
    );

    assign s_axis_tready = w_cmd.in_ready;

    // Output register decouples the computation from a stalled receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.finish) begin
            r_out_data <= dp_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, r_out_data};

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_cmd.finish)
        else $error("result written over a result still waiting");

    // After a request is taken, no second one is taken until it completes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

    // A seed write blocks requests while the history is primed.
    a_seed_primes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_fire && i_cfg_index == REG_SEED_VALUE) |=> !s_axis_tready)
        else $error("request taken during priming after seed write");

    // A finished result shows on the master stream in the next cycle.
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

`default_nettype wire

[tb/smooth_random_modulator_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for smooth_random_modulator_core: random and directed restart requests
// and register writes, each output value compared against an in-bench interpolation predictor.
// Depends on srm_pkg and the core RTL only.

module smooth_random_modulator_core_tb;
    import srm_pkg::*;

    localparam int FRAC       = 16;
    localparam int CNT_W      = 24;
    localparam int LATENCY    = FRAC + 8;
    localparam int SETTLE     = LATENCY + 16;
    localparam int MAX_WAIT   = 14;
    localparam int TOTAL_REQS = 450;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [31:0]           i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Predictor state, kept in step with the core's registers.
    logic [LEN_W-1:0]         seg_len;
    logic [SEED_W-1:0]        seed_reg;
    logic [SEED_W-1:0]        noise_word;
    logic signed [OUT_W-1:0]  hist [4];
    logic [CNT_W-1:0]         seg_count;

    bit                       pending_restart [$];
    logic signed [OUT_W-1:0]  expected_mod [$];
    logic signed [OUT_W-1:0]  mod_expect;

    bit req_busy = 1'b0;
    bit req_taken = 1'b0;
    bit tx_calm = 1'b1;
    bit rx_calm = 1'b1;
    int tx_gap = 0;
    int rx_stall = 0;
    int fail_count = 0;
    int reqs_queued = 0;
    int reqs_sent = 0;
    int results_seen = 0;
    int restarts_sent = 0;
    int seed_writes = 0;
    int len_writes = 0;

    smooth_random_modulator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One xorshift32 step, mapped to [-1, +1] in Q1.16 with round to nearest.
    function automatic logic signed [OUT_W-1:0] draw_noise();
        logic [SEED_W-1:0] x;
        longint unsigned   wide;
        longint unsigned   q;
        x = noise_word ^ (noise_word << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        noise_word = x;
        wide = x;
        q = ((wide << (FRAC + 1)) + 64'h7FFF_FFFF) / 64'hFFFF_FFFF;
        return OUT_W'(longint'(q) - (longint'(1) << FRAC));
    endfunction

    function automatic void reprime_history();
        noise_word = seed_reg;
        for (int k = 0; k < PRIME_DRAWS; k++)
            hist[k] = draw_noise();
        seg_count = '0;
    endfunction

    // Catmull-Rom value for one tick, then counter advance or segment-end clear and history shift.
    function automatic logic signed [OUT_W-1:0] interpolate_tick(input bit restart);
        longint len, pos, p0, p1, p2, p3, a, b, c, d, u, v, s, r;
        len = (seg_len == '0) ? 1 : longint'(seg_len);
        if (restart)
            seg_count = '0;
        pos = (longint'(seg_count) << FRAC) / len;
        if (pos > (longint'(1) << FRAC) - 1)
            pos = (longint'(1) << FRAC) - 1;
        p0 = hist[0];
        p1 = hist[1];
        p2 = hist[2];
        p3 = hist[3];
        a = 2 * p1;
        b = p2 - p0;
        c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d = -p0 + 3 * p1 - 3 * p2 + p3;
        u = c + ((d * pos) >>> FRAC);
        v = b + ((u * pos) >>> FRAC);
        s = a + ((v * pos) >>> FRAC);
        r = (s + 1) >>> 1;
        if (r > OUT_MAX)
            r = OUT_MAX;
        if (r < OUT_MIN)
            r = OUT_MIN;
        if (longint'(seg_count) + 1 >= len) begin
            seg_count = '0;
            hist[0] = hist[1];
            hist[1] = hist[2];
            hist[2] = hist[3];
            hist[3] = draw_noise();
        end else begin
            seg_count = seg_count + 1'b1;
        end
        return OUT_W'(r);
    endfunction

    // Request sender: one item in flight, a drawn gap after each accepted request.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_taken) begin
                req_taken = 1'b0;
                req_busy = 1'b0;
                tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!req_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_restart.size() > 0) begin
                    s_axis_tdata <= {{(S_TDATA_W-1){1'b0}}, pending_restart.pop_front()};
                    req_busy = 1'b1;
                end
            end
            s_axis_tvalid <= req_busy;
        end
    end

    // Result receiver back-pressure.
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Prediction on accepted requests and checking of accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_mod.push_back(interpolate_tick(s_axis_tdata[0]));
                req_taken = 1'b1;
                reqs_sent++;
                if (s_axis_tdata[0])
                    restarts_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if (expected_mod.size() == 0) begin
                    $error("unexpected result: mod_value actual %0d",
                           $signed(m_axis_tdata[OUT_W-1:0]));
                    fail_count++;
                end else begin
                    mod_expect = expected_mod.pop_front();
                    if (m_axis_tdata[OUT_W-1:0] !== mod_expect) begin
                        $error("mod_value mismatch: expected %0d actual %0d",
                               mod_expect, $signed(m_axis_tdata[OUT_W-1:0]));
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SEGMENT_LENGTH: begin
                seg_len = data[LEN_W-1:0];
                len_writes++;
            end
            REG_SEED_VALUE: begin
                seed_reg = data;
                reprime_history();
                seed_writes++;
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every queued request is answered, then lets the core settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_restart.size() != 0 || req_busy || expected_mod.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_ticks(input int count, input int restart_pct);
        for (int k = 0; k < count; k++)
            pending_restart.push_back($urandom_range(0, 99) < restart_pct);
        reqs_queued += count;
        wait_idle();
    endtask

    task automatic run_pattern(input bit [7:0] pattern, input int count);
        for (int k = 0; k < count; k++)
            pending_restart.push_back(pattern[k]);
        reqs_queued += count;
        wait_idle();
    endtask

    initial begin
        int len_pick;
        int count;

        seg_len  = SEG_LEN_RESET;
        seed_reg = SEED_RESET;
        reprime_history();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults, with a restart in the run.
        run_pattern(8'b0000_0100, 4);
        // Unused register indexes must change nothing.
        write_reg(2'd2, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'hFFFF_FFFF);
        run_pattern(8'b0000_0000, 1);
        // Every tick ends a segment; a zero length behaves the same way.
        write_reg(REG_SEGMENT_LENGTH, 32'd1);
        run_pattern(8'b0000_0010, 2);
        write_reg(REG_SEGMENT_LENGTH, 32'd0);
        run_pattern(8'b0000_0001, 2);
        // A zero seed keeps the generator at zero, so every draw is -1.0.
        write_reg(REG_SEED_VALUE, 32'd0);
        write_reg(REG_SEGMENT_LENGTH, 32'd4);
        run_pattern(8'b0000_0000, 3);
        // Shortening the length below the running count saturates t and ends the segment.
        write_reg(REG_SEED_VALUE, 32'hFFFF_FFFF);
        write_reg(REG_SEGMENT_LENGTH, 32'd10);
        run_pattern(8'b0000_0000, 7);
        write_reg(REG_SEGMENT_LENGTH, 32'd3);
        run_pattern(8'b0000_0000, 2);
        // Longest segment.
        write_reg(REG_SEGMENT_LENGTH, 32'h00FF_FFFF);
        run_pattern(8'b0000_0010, 3);

        while (reqs_queued < TOTAL_REQS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            len_pick = $urandom_range(0, 99);
            if (len_pick < 60)
                write_reg(REG_SEGMENT_LENGTH, $urandom_range(1, 12));
            else if (len_pick < 75)
                write_reg(REG_SEGMENT_LENGTH, $urandom_range(13, 200));
            else if (len_pick < 85)
                write_reg(REG_SEGMENT_LENGTH, 32'd0);
            else if (len_pick < 92)
                write_reg(REG_SEGMENT_LENGTH, 32'h00FF_FFFF);
            else
                write_reg(REG_SEGMENT_LENGTH, $urandom);
            if ($urandom_range(0, 99) < 40)
                write_reg(REG_SEED_VALUE, ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 3)), $urandom);
            count = $urandom_range(10, 40);
            run_ticks(count, 12);
        end

        $display("Covered %0d requests (%0d with restart) and %0d results,",
                 reqs_sent, restarts_sent, results_seen);
        $display("with %0d length writes and %0d seed writes under random back-pressure.",
                 len_writes, seed_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
